@@ sv/twsfr_pkg.sv @@
package twsfr_pkg;

  localparam logic [7:0] HdrFirst    = 8'h7A;
  localparam logic [7:0] HdrSecond   = 8'h62;
  localparam logic [7:0] CmdSleep    = 8'h02;
  localparam logic [2:0] PosIdle     = 3'd0;
  localparam logic [2:0] PosHeader   = 3'd1;
  localparam logic [2:0] PosPayload  = 3'd2;
  localparam logic [2:0] PosLastSlot = 3'd4;
  localparam logic [2:0] PosFrameEnd = 3'd6;
  localparam logic [1:0] ToggleMax   = 2'd3;
  localparam logic [4:0] RxLastBit   = 5'd7;
  localparam logic [4:0] TxLastBit   = 5'd31;

  typedef struct packed {
    logic        data_level;
    logic        clock_level;
    logic [15:0] response_low;
    logic [15:0] response_high;
  } in_req_t;

  typedef struct packed {
    logic        drive_enable;
    logic        drive_level;
    logic        byte_done;
    logic [7:0]  byte_value;
    logic        frame_done;
    logic [7:0]  command_byte;
    logic        sleep_request;
    logic [15:0] sleep_time;
  } out_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
  } rx_byte_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  command_byte;
    logic [15:0] sleep_time;
  } frame_t;

endpackage

@@ sv/twsfr_parser.sv @@
module twsfr_parser
  import twsfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rx_byte_t rx_byte_i,
  output frame_t   frame_o
);

  logic [2:0] pos_q, pos_d, pos_inc;
  logic [7:0] store_q [3];
  logic [1:0] slot;
  logic       done;

  always_comb begin
    pos_d   = pos_q;
    pos_inc = pos_q + 3'd1;
    slot    = 2'(pos_q - PosPayload);
    done    = 1'b0;
    if (pos_q >= PosPayload) begin
      pos_d = pos_inc;
      if (pos_inc >= PosFrameEnd) begin
        pos_d = PosIdle;
        done  = 1'b1;
      end
    end
    if (rx_byte_i.value == HdrSecond) begin
      pos_d = (pos_d == PosHeader) ? PosPayload : PosIdle;
    end
    if (rx_byte_i.value == HdrFirst && pos_d == PosIdle) begin
      pos_d = PosHeader;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosIdle;
    end else if (rx_byte_i.valid) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_byte_i.valid && pos_q >= PosPayload && pos_q <= PosLastSlot) begin
      store_q[slot] <= rx_byte_i.value;
    end
  end

  always_comb begin
    frame_o.done         = rx_byte_i.valid && done;
    frame_o.command_byte = store_q[0];
    frame_o.sleep_time   = {store_q[2], store_q[1]};
  end

endmodule

@@ sv/twsfr_core.sv @@
module twsfr_core
  import twsfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_req_t  req_i,
  output out_req_t res_o
);

  logic       last_data_q, last_clock_q, sending_q, sent_q;
  logic       sending_d, sent_d;
  logic [1:0] tog_q, tog_d, tog_cnt;
  logic [4:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d, shift_new;
  logic       clock_changed, rising, byte_end;
  logic [31:0] resp;
  rx_byte_t   rx_byte;
  frame_t     frame;

  twsfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (rx_byte),
    .frame_o   (frame)
  );

  always_comb begin
    clock_changed = req_i.clock_level != last_clock_q;
    rising        = clock_changed && req_i.clock_level;
    shift_new     = shift_q | (8'(req_i.data_level) << bit_q[2:0]);
    tog_cnt       = tog_q;
    if (req_i.data_level != last_data_q && tog_q < ToggleMax) begin
      tog_cnt = tog_q + 2'd1;
    end
    if (clock_changed) begin
      tog_cnt = 2'd0;
    end
    byte_end      = !sending_q && tog_cnt < ToggleMax && rising && bit_q >= RxLastBit;
    rx_byte.valid = step_i && byte_end;
    rx_byte.value = shift_new;
  end

  always_comb begin
    resp      = {req_i.response_high, req_i.response_low};
    tog_d     = tog_cnt;
    bit_d     = bit_q;
    shift_d   = shift_q;
    sending_d = sending_q;
    sent_d    = sent_q;

    if (!sending_q) begin
      if (tog_cnt >= ToggleMax) begin
        tog_d   = 2'd0;
        bit_d   = 5'd0;
        shift_d = 8'd0;
      end else if (rising) begin
        if (bit_q >= RxLastBit) begin
          bit_d   = 5'd0;
          shift_d = 8'd0;
          if (frame.done) begin
            sending_d = 1'b1;
            sent_d    = 1'b0;
          end
        end else begin
          bit_d   = bit_q + 5'd1;
          shift_d = shift_new;
        end
      end
    end else if (rising) begin
      sent_d = resp[bit_q];
      bit_d  = bit_q + 5'd1;
      if (bit_q == TxLastBit) begin
        sending_d = 1'b0;
        bit_d     = 5'd0;
        sent_d    = 1'b0;
      end
    end

    res_o.drive_enable  = sending_d;
    res_o.drive_level   = sending_d && sent_d;
    res_o.byte_done     = rx_byte.valid;
    res_o.byte_value    = rx_byte.valid ? rx_byte.value : 8'd0;
    res_o.frame_done    = frame.done;
    res_o.command_byte  = frame.done ? frame.command_byte : 8'd0;
    res_o.sleep_request = frame.done && frame.command_byte == CmdSleep;
    res_o.sleep_time    = frame.done ? frame.sleep_time : 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_data_q  <= 1'b0;
      last_clock_q <= 1'b0;
      tog_q        <= 2'd0;
      bit_q        <= 5'd0;
      shift_q      <= 8'd0;
      sending_q    <= 1'b0;
      sent_q       <= 1'b0;
    end else if (step_i) begin
      last_data_q  <= req_i.data_level;
      last_clock_q <= req_i.clock_level;
      tog_q        <= tog_d;
      bit_q        <= bit_d;
      shift_q      <= shift_d;
      sending_q    <= sending_d;
      sent_q       <= sent_d;
    end
  end

endmodule

@@ sv/two_wire_slave_frame_receiver_top.sv @@
// Path: an accepted request is captured in the input register, and its result
// is captured in the result register behind the pin-event logic.
// Throughput: one request per cycle unless the output stalls; event logic sets it.
// Reset: line history, toggle count, shifter, parser position and send
// state clear at once; the three payload bytes hold no reset value.
module two_wire_slave_frame_receiver_top
  import twsfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  logic     in_valid_q, out_valid_q;
  in_req_t  in_req_q;
  out_req_t out_req_q, res;
  logic     out_adv, step;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;

  twsfr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_req_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
    if (step) begin
      out_req_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule
